FILE: rtl/bispectrum_box_smoother_defines.svh
// Assertion macros used by the block's top level.
`ifndef BISPECTRUM_BOX_SMOOTHER_DEFINES_SVH
`define BISPECTRUM_BOX_SMOOTHER_DEFINES_SVH

// Asserts that a property holds on every rising clock edge outside reset.
`define BBS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Asserts that an antecedent implies a consequent in the next cycle.
`define BBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bbs_pkg.sv
// Package with the types and constants of the box smoother.
`timescale 1ns / 1ps
package bbs_pkg;

  localparam int unsigned LengthDef = 256;
  localparam int unsigned MaxWindowDef = 32;
  localparam int unsigned PrefW = 58;
  localparam int unsigned OutW = 48;
  localparam int unsigned ScaleW = 25;
  localparam int unsigned WinW = 6;

  localparam logic OpLoad = 1'b0;
  localparam logic OpStep = 1'b1;

  localparam logic [1:0] RegWindow = 2'd0;
  localparam logic [1:0] RegScale = 2'd1;

  typedef struct packed {
    logic               operation;
    logic [7:0]         index;
    logic signed [15:0] coef_real;
    logic signed [15:0] coef_imag;
  } bbs_in_t;

  typedef struct packed {
    logic [7:0]            out_row;
    logic [7:0]            out_col;
    logic signed [47:0]    bispec_real;
    logic signed [47:0]    bispec_imag;
    logic                  last;
  } bbs_out_t;

endpackage

FILE: rtl/bbs_scale.sv
// Scaling of a box sum by scale_i / 2^24 with floor and 48-bit saturation.
`timescale 1ns / 1ps
module bbs_scale import bbs_pkg::*; (
  input  logic                     clk_i,
  input  logic signed [PrefW-1:0]  box_i,
  input  logic [ScaleW-1:0]        scale_i,
  output logic signed [OutW-1:0]   res_o
);

  logic              neg_q;
  logic [PrefW-1:0]  mag;
  logic [57:0]       hi_prod_q;
  logic [48:0]       lo_prod_q;
  logic [58:0]       q;
  logic [PrefW-1:0]  neg_box;

  // Stage one: split the magnitude and form two partial products.
  assign neg_box = PrefW'(-box_i);
  assign mag = box_i[PrefW-1] ? neg_box : box_i;

  always_ff @(posedge clk_i) begin
    neg_q     <= box_i[PrefW-1];
    hi_prod_q <= 58'(mag[PrefW-1:24]) * 58'(scale_i);
    lo_prod_q <= 49'(mag[23:0]) * 49'(scale_i);
  end

  // Stage two: combine, round toward minus infinity, saturate.
  always_comb begin
    q = 59'(hi_prod_q) + 59'(lo_prod_q[48:24]);
    if (neg_q && (lo_prod_q[23:0] != '0)) begin
      q = q + 59'd1;
    end
    if (!neg_q) begin
      res_o = (q > 59'h7FFF_FFFF_FFFF) ? 48'sh7FFF_FFFF_FFFF : OutW'(q);
    end else if (q > 59'h8000_0000_0000) begin
      res_o = 48'sh8000_0000_0000;
    end else begin
      res_o = OutW'(-q);
    end
  end

endmodule

FILE: rtl/bispectrum_box_smoother.sv
// Box smoother top level: coefficient store, prefix ring and cell sequencer.
`timescale 1ns / 1ps
// A load transaction keeps busy high for one cycle. A step transaction keeps busy high
// until its result is formed, and no new transaction is accepted while busy is high.
// A step passes through three coefficient reads on the single store port, two
// multiply stages of the complex triple product, six prefix-ring reads and one write
// on the single ring port, and the scaling states StScl and StOut. A result is shown
// for one cycle on result_valid_o, only for a cell that emits, in the same cycle that
// busy falls, and cannot be held off.
`include "bispectrum_box_smoother_defines.svh"
module bispectrum_box_smoother import bbs_pkg::*; #(
  parameter int unsigned LENGTH = LengthDef,
  parameter int unsigned MAX_WINDOW = MaxWindowDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  bbs_in_t     item_i,
  output logic        result_valid_o,
  output bbs_out_t    result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned LW = $clog2(LENGTH);
  localparam int unsigned RingRows = MAX_WINDOW + 1;
  localparam int unsigned RW = $clog2(RingRows + 1);
  localparam int unsigned AW = $clog2(RingRows * LENGTH);
  localparam int unsigned MW = $clog2(MAX_WINDOW + 1);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StRdA  = 4'd1;
  localparam logic [3:0] StRdB  = 4'd2;
  localparam logic [3:0] StRdC  = 4'd3;
  localparam logic [3:0] StMul  = 4'd4;
  localparam logic [3:0] StMul2 = 4'd5;
  localparam logic [3:0] StPre  = 4'd6;
  localparam logic [3:0] StBox  = 4'd7;
  localparam logic [3:0] StScl  = 4'd8;
  localparam logic [3:0] StOut  = 4'd9;
  localparam logic [3:0] StLoad = 4'd10;

  logic [3:0] st_q, st_d;
  logic [WinW-1:0] window_q;
  logic [ScaleW-1:0] scale_q;
  logic cfg_wr;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WinW'(32);
      scale_q  <= ScaleW'(16384);
    end else if (cfg_wr) begin
      if (paddr[2] == RegScale[0]) begin
        scale_q <= pwdata[ScaleW-1:0];
      end else begin
        window_q <= pwdata[WinW-1:0];
      end
    end
  end
  assign prdata = paddr[2] ? 32'(scale_q) : 32'(window_q);

  // Coefficient store: one synchronous port.
  logic [31:0] cstore [LENGTH];
  logic [31:0] crd_q;
  logic [LW-1:0] caddr;
  logic cwe;
  bbs_in_t in_q;
  always_ff @(posedge clk_i) begin
    if (cwe) begin
      cstore[caddr] <= {in_q.coef_real, in_q.coef_imag};
    end
    crd_q <= cstore[caddr];
  end

  // Sweep position.
  logic [LW-1:0] row_q, col_q;
  logic [LW:0] rsum;
  logic active;
  assign rsum = {1'b0, row_q} + {1'b0, col_q};
  assign active = (col_q <= row_q) && ({rsum, 1'b0} < (LW+2)'(LENGTH));

  logic signed [15:0] ar_q, ai_q;
  logic signed [32:0] pr_q, pi_q;
  logic signed [49:0] t1_q, t2_q, t3_q, t4_q;
  logic signed [PrefW-1:0] vre, vim;

  // Triple product, one multiply level per register.
  always_ff @(posedge clk_i) begin
    if (st_q == StRdB) begin
      {ar_q, ai_q} <= crd_q;
    end
    if (st_q == StRdC) begin
      pr_q <= 33'(ar_q * $signed(crd_q[31:16])) - 33'(ai_q * $signed(crd_q[15:0]));
      pi_q <= 33'(ar_q * $signed(crd_q[15:0])) + 33'(ai_q * $signed(crd_q[31:16]));
    end
    if (st_q == StMul) begin
      t1_q <= 50'(pr_q * $signed(crd_q[31:16]));
      t2_q <= 50'(pi_q * $signed(crd_q[15:0]));
      t3_q <= 50'(pi_q * $signed(crd_q[31:16]));
      t4_q <= 50'(pr_q * $signed(crd_q[15:0]));
    end
  end
  logic signed [49:0] sre, sim;
  assign sre = t1_q + t2_q;
  assign sim = t3_q - t4_q;
  assign vre = active ? PrefW'(sre >>> LW) : '0;
  assign vim = active ? PrefW'(sim >>> LW) : '0;

  // Window clamp and ring row arithmetic.
  logic [MW-1:0] w;
  always_comb begin
    if (window_q == '0) w = MW'(1);
    else if (window_q > WinW'(MAX_WINDOW)) w = MW'(MAX_WINDOW);
    else w = MW'(window_q);
  end
  logic [RW-1:0] slot_q, slot_m1, slot_mw;
  assign slot_m1 = (slot_q == '0) ? RW'(RingRows - 1) : slot_q - RW'(1);
  assign slot_mw = (slot_q >= RW'(w)) ? slot_q - RW'(w) : slot_q + RW'(RingRows) - RW'(w);

  // Prefix ring memory, one synchronous port of real and imaginary parts.
  logic [2*PrefW-1:0] ring [RingRows * LENGTH];
  logic [2*PrefW-1:0] rrd_q;
  logic [AW-1:0] raddr;
  logic rwe;
  logic [2*PrefW-1:0] rwdata;
  always_ff @(posedge clk_i) begin
    if (rwe) begin
      ring[raddr] <= rwdata;
    end
    rrd_q <= ring[raddr];
  end

  // Read sub-step counter and accumulators.
  logic [2:0] k_q;
  logic signed [PrefW-1:0] acc_re_q, acc_im_q;
  logic signed [PrefW-1:0] box_re_q, box_im_q;
  logic rv_q;
  logic [RW-1:0] rrow;
  logic [LW-1:0] rcol;
  logic rok;
  logic emit;
  assign emit = ({1'b0, row_q} + (LW+1)'(1) >= (LW+1)'(w))
             && ({1'b0, col_q} + (LW+1)'(1) >= (LW+1)'(w));

  always_comb begin
    rrow = slot_m1;
    rcol = col_q;
    rok  = 1'b0;
    unique case (k_q)
      3'd0: begin rrow = slot_m1; rok = row_q != '0; end
      3'd1: begin rrow = slot_q; rcol = col_q - LW'(1); rok = col_q != '0; end
      3'd2: begin rrow = slot_m1; rcol = col_q - LW'(1);
                  rok = (row_q != '0) && (col_q != '0); end
      3'd3: begin rrow = slot_mw; rok = {1'b0, row_q} >= (LW+1)'(w); end
      3'd4: begin rrow = slot_q; rcol = col_q - LW'(w);
                  rok = {1'b0, col_q} >= (LW+1)'(w); end
      3'd5: begin rrow = slot_mw; rcol = col_q - LW'(w);
                  rok = ({1'b0, row_q} >= (LW+1)'(w)) && ({1'b0, col_q} >= (LW+1)'(w)); end
      default: begin rrow = slot_q; rok = 1'b0; end
    endcase
  end

  logic signed [PrefW-1:0] own_re, own_im;
  assign own_re = acc_re_q;
  assign own_im = acc_im_q;

  // The own prefix entry is written in the last box cycle, after all six reads.
  always_comb begin
    raddr  = AW'(rrow * LENGTH) + AW'(rcol);
    rwe    = (st_q == StBox) && (k_q == 3'd6);
    rwdata = {own_re, own_im};
    if (rwe) begin
      raddr = AW'(slot_q * LENGTH) + AW'(col_q);
    end
  end

  logic [2:0] kp_q;
  logic signed [PrefW-1:0] dre, dim;
  assign dre = rv_q ? rrd_q[2*PrefW-1:PrefW] : '0;
  assign dim = rv_q ? rrd_q[PrefW-1:0] : '0;

  // Ring sequencing: reads k 0..2 build the prefix, reads k 3..5 fetch the box
  // corners, and the write follows at k 6.
  always_ff @(posedge clk_i) begin
    rv_q <= rok;
    kp_q <= k_q;
    if (st_q == StPre) begin
      if (k_q == 3'd0) begin
        acc_re_q <= vre;
        acc_im_q <= vim;
      end
      if (k_q != 3'd0 || kp_q != 3'd7) begin
        if (kp_q == 3'd2) begin
          acc_re_q <= acc_re_q - dre;
          acc_im_q <= acc_im_q - dim;
        end else if (kp_q <= 3'd1) begin
          acc_re_q <= acc_re_q + dre;
          acc_im_q <= acc_im_q + dim;
        end
      end
    end
    if (st_q == StBox) begin
      if (k_q == 3'd3) begin
        if (kp_q == 3'd2) begin
          acc_re_q <= acc_re_q - dre;
          acc_im_q <= acc_im_q - dim;
        end
        box_re_q <= '0;
        box_im_q <= '0;
      end else if (kp_q == 3'd3) begin
        box_re_q <= acc_re_q - dre;
        box_im_q <= acc_im_q - dim;
      end else if (kp_q == 3'd4) begin
        box_re_q <= box_re_q - dre;
        box_im_q <= box_im_q - dim;
      end else if (kp_q == 3'd5) begin
        box_re_q <= box_re_q + dre;
        box_im_q <= box_im_q + dim;
      end
    end
  end

  // Scaling unit.
  logic signed [OutW-1:0] sc_re, sc_im;
  bbs_scale u_scale_re (.clk_i(clk_i), .box_i(box_re_q), .scale_i(scale_q), .res_o(sc_re));
  bbs_scale u_scale_im (.clk_i(clk_i), .box_i(box_im_q), .scale_i(scale_q), .res_o(sc_im));

  // Sequencer.
  logic [LW-1:0] orow_q, ocol_q;
  logic olast_q, oemit_q;
  always_comb begin
    st_d  = st_q;
    cwe   = 1'b0;
    caddr = row_q;
    unique case (st_q)
      StIdle: if (start) st_d = (item_i.operation == OpStep) ? StRdA : StLoad;
      StLoad: begin
        caddr = LW'(in_q.index);
        cwe = ({2'b0, in_q.index} < 10'(LENGTH)) || (LW >= 8);
        st_d = StIdle;
      end
      StRdA: begin caddr = row_q; st_d = StRdB; end
      StRdB: begin caddr = col_q; st_d = StRdC; end
      StRdC: begin caddr = LW'(rsum); st_d = StMul; end
      StMul: st_d = StMul2;
      StMul2: st_d = StPre;
      StPre: if (k_q == 3'd2) st_d = StBox;
      StBox: if (k_q == 3'd6) st_d = StScl;
      StScl: st_d = StOut;
      StOut: st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      k_q <= 3'd7;
      row_q <= '0;
      col_q <= '0;
      slot_q <= '0;
      oemit_q <= 1'b0;
      result_valid_o <= 1'b0;
      in_q <= '0;
      orow_q <= '0;
      ocol_q <= '0;
      olast_q <= 1'b0;
    end else begin
      st_q <= st_d;
      result_valid_o <= (st_q == StOut) && oemit_q;
      if (st_q == StIdle && start) begin
        in_q <= item_i;
      end
      if (st_q == StMul2) k_q <= 3'd0;
      else if (st_q == StPre || st_q == StBox) k_q <= k_q + 3'd1;
      else k_q <= 3'd7;
      if (st_q == StBox && k_q == 3'd6) begin
        orow_q <= row_q - LW'(w) + LW'(1);
        ocol_q <= col_q - LW'(w) + LW'(1);
        olast_q <= (row_q == LW'(LENGTH - 1)) && (col_q == LW'(LENGTH - 1));
        oemit_q <= emit;
        col_q <= col_q + LW'(1);
        if (col_q == LW'(LENGTH - 1)) begin
          row_q <= row_q + LW'(1);
          slot_q <= (slot_q == RW'(RingRows - 1)) ? '0 : slot_q + RW'(1);
          if (row_q == LW'(LENGTH - 1)) slot_q <= '0;
        end
      end
    end
  end

  assign busy = st_q != StIdle;
  always_ff @(posedge clk_i) begin
    if (st_q == StOut) begin
      result_o.out_row <= 8'(orow_q);
      result_o.out_col <= 8'(ocol_q);
      result_o.bispec_real <= sc_re;
      result_o.bispec_imag <= sc_im;
      result_o.last <= olast_q;
    end
  end

  `BBS_ASSERT(a_no_start_busy, clk_i, rst_ni, !(result_valid_o && st_q == StOut), "result overlaps output state")
  `BBS_ASSERT_NEXT(a_out_idle, clk_i, rst_ni, st_q == StOut, st_q == StIdle, "output state did not return idle")
  `BBS_ASSERT(a_ring_wr, clk_i, rst_ni, !(rwe && cwe), "both memories written together")

endmodule

FILE: tb/sv/bispectrum_box_smoother_tb.sv
// Self-checking testbench for the bispectrum box smoother top level.
`timescale 1ns / 1ps
module bispectrum_box_smoother_tb;
  import bbs_pkg::*;

  localparam int unsigned Bins = 256;
  localparam int unsigned RingRows = 33;
  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned SettleCycles = 16;
  localparam logic [2:0] AddrWindow = {RegWindow, 1'b0} << 1;
  localparam logic [2:0] AddrScale = {RegScale, 1'b0} << 1;
  localparam logic signed [127:0] SatHigh = (128'sd1 <<< 47) - 128'sd1;
  localparam logic signed [127:0] SatLow = -(128'sd1 <<< 47);

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  bbs_in_t     item_i;
  logic        result_valid_o;
  bbs_out_t    result_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Shadow copy of the block's state.
  logic signed [15:0] spec_re [Bins];
  logic signed [15:0] spec_im [Bins];
  logic [57:0]        pfx_re [RingRows*Bins];
  logic [57:0]        pfx_im [RingRows*Bins];
  int                 cur_row;
  int                 cur_col;
  int                 win_reg;
  longint             scale_reg;

  bbs_out_t    estimate_q[$];
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  bit          calm;

  bispectrum_box_smoother DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .item_i(item_i),
    .result_valid_o(result_valid_o), .result_o(result_o), .psel(psel),
    .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #1 clk_i = ~clk_i;

  // Run-time guard.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("bispectrum_box_smoother_tb: FAIL");
      $finish;
    end
  end

  function automatic logic [57:0] pfx_at(bit im, int r, int c);
    if (r < 0 || c < 0) return 58'd0;
    return im ? pfx_im[(r % RingRows) * Bins + c] : pfx_re[(r % RingRows) * Bins + c];
  endfunction

  // Floor of box*scale/2^24, clamped to 48 bits.
  function automatic logic [47:0] scaled_clamp(longint box, longint scale);
    logic signed [127:0] bx;
    logic signed [127:0] sc;
    logic signed [127:0] p;
    bx = box;
    sc = scale;
    p = (bx * sc) >>> 24;
    if (p > SatHigh) p = SatHigh;
    if (p < SatLow) p = SatLow;
    return p[47:0];
  endfunction

  function automatic longint box_of(bit im, int r, int c, int w);
    logic [57:0] s;
    s = pfx_at(im, r, c) - pfx_at(im, r - w, c) - pfx_at(im, r, c - w)
      + pfx_at(im, r - w, c - w);
    return longint'($signed(s));
  endfunction

  // Advance the shadow state by one accepted transaction and queue any estimate.
  task automatic predict_estimate(bbs_in_t it);
    longint ar, ai, br, bi, cr, ci, pr, pim, vre, vim;
    int r, c, w, slot;
    bbs_out_t est;
    if (it.operation == OpLoad) begin
      spec_re[it.index] = it.coef_real;
      spec_im[it.index] = it.coef_imag;
      return;
    end
    r = cur_row;
    c = cur_col;
    vre = 0;
    vim = 0;
    if (c <= r && 2 * (r + c) < Bins) begin
      ar = spec_re[r]; ai = spec_im[r];
      br = spec_re[c]; bi = spec_im[c];
      cr = spec_re[r + c]; ci = spec_im[r + c];
      pr = ar * br - ai * bi;
      pim = ar * bi + ai * br;
      vre = (pr * cr + pim * ci) >>> 8;
      vim = (pim * cr - pr * ci) >>> 8;
    end
    slot = (r % RingRows) * Bins + c;
    pfx_re[slot] = 58'(vre) + pfx_at(0, r - 1, c) + pfx_at(0, r, c - 1)
                 - pfx_at(0, r - 1, c - 1);
    pfx_im[slot] = 58'(vim) + pfx_at(1, r - 1, c) + pfx_at(1, r, c - 1)
                 - pfx_at(1, r - 1, c - 1);
    cur_col++;
    if (cur_col >= Bins) begin
      cur_col = 0;
      cur_row = (cur_row + 1 >= Bins) ? 0 : cur_row + 1;
    end
    w = win_reg;
    if (w < 1) w = 1;
    if (w > 32) w = 32;
    if (r + 1 < w || c + 1 < w) return;
    est.out_row = 8'(r - w + 1);
    est.out_col = 8'(c - w + 1);
    est.bispec_real = scaled_clamp(box_of(0, r, c, w), scale_reg);
    est.bispec_imag = scaled_clamp(box_of(1, r, c, w), scale_reg);
    est.last = (r == Bins - 1) && (c == Bins - 1);
    estimate_q = {estimate_q, est};
  endtask

  // Compare every result with the oldest queued estimate.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (estimate_q.size() == 0) begin
        err_cnt++;
        if (err_cnt < 40) $error("unexpected result row %0d col %0d",
                                 result_o.out_row, result_o.out_col);
      end else begin
        bbs_out_t e;
        e = estimate_q.pop_front();
        if (result_o.out_row !== e.out_row) begin
          err_cnt++;
          if (err_cnt < 40) $error("out_row exp %0d got %0d", e.out_row, result_o.out_row);
        end
        if (result_o.out_col !== e.out_col) begin
          err_cnt++;
          if (err_cnt < 40) $error("out_col exp %0d got %0d", e.out_col, result_o.out_col);
        end
        if (result_o.bispec_real !== e.bispec_real) begin
          err_cnt++;
          if (err_cnt < 40) $error("bispec_real exp %0d got %0d", e.bispec_real,
                                   result_o.bispec_real);
        end
        if (result_o.bispec_imag !== e.bispec_imag) begin
          err_cnt++;
          if (err_cnt < 40) $error("bispec_imag exp %0d got %0d", e.bispec_imag,
                                   result_o.bispec_imag);
        end
        if (result_o.last !== e.last) begin
          err_cnt++;
          if (err_cnt < 40) $error("last exp %0d got %0d", e.last, result_o.last);
        end
      end
    end
  end

  function automatic bbs_in_t make_item(logic op, logic [7:0] idx, logic [15:0] re,
                                        logic [15:0] im);
    bbs_in_t it;
    it.operation = op;
    it.index = idx;
    it.coef_real = re;
    it.coef_imag = im;
    return it;
  endfunction

  // Issue one transaction; start is left high so back-to-back items need no gap.
  task automatic send_item(bbs_in_t it);
    if (!calm && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    start <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    predict_estimate(it);
  endtask

  // Hold off until every estimate has arrived and the block is idle.
  task automatic drain;
    start <= 1'b0;
    @(posedge clk_i);
    while (estimate_q.size() != 0 || busy) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    if (addr == AddrWindow) win_reg = data & 32'h3F;
    else scale_reg = data & 32'h1FF_FFFF;
  endtask

  task automatic set_smoothing(int w, longint s);
    write_reg(AddrWindow, 32'(w));
    write_reg(AddrScale, 32'(s));
  endtask

  function automatic logic [15:0] pick_coef();
    case ($urandom_range(0, 4))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Write every bin with large values so nothing unwritten is ever read.
  task automatic test_fill_spectrum;
    for (int i = 0; i < Bins; i++)
      send_item(make_item(OpLoad, 8'(i), (i % 3 == 0) ? 16'h8000 : 16'h7FFF,
                          (i % 2 == 0) ? 16'h7FFF : 16'h8000));
  endtask

  // Window zero and one emit on every cell; an oversize window acts as the maximum.
  task automatic test_window_extremes;
    set_smoothing(1, 24'hFF_FFFF + 1);
    repeat (4) send_item(make_item(OpStep, 8'hFF, 16'hFFFF, 16'hFFFF));
    set_smoothing(0, 25'h1FF_FFFF);
    repeat (4) send_item(make_item(OpStep, 8'h00, 16'h0000, 16'h0000));
    set_smoothing(63, 0);
    repeat (4) send_item(make_item(OpStep, 8'h5A, 16'h1234, 16'h8765));
    // A load in mid sweep is used from the next cell on.
    set_smoothing(2, 4194304);
    send_item(make_item(OpLoad, 8'd1, 16'h8000, 16'h8000));
    repeat (3) send_item(make_item(OpStep, 8'h00, 16'h0000, 16'h0000));
  endtask

  // Random mix of loads and steps under changing smoothing settings.
  task automatic test_random_mix;
    bbs_in_t it;
    for (int ph = 0; ph < 3; ph++) begin
      set_smoothing((ph == 0) ? 32 : $urandom_range(0, 63),
                    (ph == 1) ? 0 : $urandom_range(0, 25'h1FF_FFFF));
      for (int n = 0; n < 100; n++) begin
        it = make_item($urandom_range(0, 9) < 7 ? OpStep : OpLoad, 8'($urandom),
                       pick_coef(), pick_coef());
        send_item(it);
      end
    end
  endtask

  // The sender stops until all outstanding estimates are back, then resumes.
  task automatic test_pause_for_results;
    set_smoothing(1, 16384);
    repeat (5) send_item(make_item(OpStep, 8'($urandom), 16'($urandom), 16'($urandom)));
    drain();
    repeat (5) send_item(make_item(OpStep, 8'($urandom), 16'($urandom), 16'($urandom)));
  endtask

  // Close the run with steps sent back to back and no idling in between.
  task automatic test_back_to_back;
    calm = 1'b1;
    set_smoothing(2, 4194304);
    repeat (40) send_item(make_item(OpStep, 8'($urandom), pick_coef(), pick_coef()));
  endtask

  initial begin
    rst_ni <= 1'b0;
    start <= 1'b0;
    item_i <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    err_cnt = 0;
    cycle_cnt = 0;
    calm = 1'b0;
    cur_row = 0;
    cur_col = 0;
    win_reg = 32;
    scale_reg = 16384;
    for (int i = 0; i < RingRows * Bins; i++) begin
      pfx_re[i] = '0;
      pfx_im[i] = '0;
    end
    for (int i = 0; i < Bins; i++) begin
      spec_re[i] = '0;
      spec_im[i] = '0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_fill_spectrum();
    test_window_extremes();
    test_random_mix();
    test_pause_for_results();
    test_back_to_back();

    drain();
    if (estimate_q.size() != 0) begin
      err_cnt++;
      $error("%0d estimates never arrived", estimate_q.size());
    end
    if (err_cnt == 0) begin
      $display("bispectrum_box_smoother_tb: PASS");
    end else begin
      $display("bispectrum_box_smoother_tb: FAIL");
    end
    $finish;
  end

endmodule
